### rtl/core/mcs_pkg.sv
// ----------------------------------------------------------------------------
// Mip chain size package
// Shared constants, format decode and byte rounding helpers, and the token
// that travels along the level cell chain.
// ----------------------------------------------------------------------------
package mcs_pkg;

   // default number of mip levels that are sized
   localparam int MAX_LEVELS_DEF = 4;
   // levels that have a result field of their own
   localparam int LEVEL_FIELDS   = 4;

   localparam int DIM_W   = 11;  // width / height
   localparam int FMT_W   = 4;   // format code
   localparam int CNT_W   = 4;   // level count
   localparam int PENT_W  = 15;  // palette entry count
   localparam int PIX_W   = 2 * DIM_W;  // pixel count of one level
   localparam int BYTE_W  = PIX_W + 2;  // whole bytes at 32 bpp
   localparam int ALN_W   = BYTE_W + 1; // bytes after alignment
   localparam int SUM_W   = 23;  // totals and level field storage
   localparam int PAL_W   = PENT_W + 3; // aligned palette bytes

   // pixel format codes
   localparam logic [FMT_W-1:0] FMT_P4_A  = 4'd0;
   localparam logic [FMT_W-1:0] FMT_P8_A  = 4'd1;
   localparam logic [FMT_W-1:0] FMT_P16_A = 4'd2;
   localparam logic [FMT_W-1:0] FMT_P16_B = 4'd4;
   localparam logic [FMT_W-1:0] FMT_P16_C = 4'd5;
   localparam logic [FMT_W-1:0] FMT_P32   = 4'd6;
   localparam logic [FMT_W-1:0] FMT_P4_B  = 4'd8;
   localparam logic [FMT_W-1:0] FMT_P8_B  = 4'd9;
   localparam logic [FMT_W-1:0] FMT_P4_C  = 4'd14;

   typedef enum logic [2:0] {
      BPP_NONE = 3'd0,
      BPP_4    = 3'd1,
      BPP_8    = 3'd2,
      BPP_16   = 3'd3,
      BPP_32   = 3'd4
   } bpp_type;

   typedef struct packed {
      logic [DIM_W-1:0]                   width;      // already shifted for this level
      logic [DIM_W-1:0]                   height;
      bpp_type                            bpp;
      logic [CNT_W-1:0]                   remaining;  // levels still to size
      logic [LEVEL_FIELDS-1:0][SUM_W-1:0] level_bytes;
      logic [PAL_W-1:0]                   palette_bytes;
      logic [SUM_W-1:0]                   total_bytes;
      logic [SUM_W-1:0]                   raw_bytes;
      logic                               clamped;
   } mcs_tok_type;

   function automatic bpp_type fmt_to_bpp(input logic [FMT_W-1:0] code);
      bpp_type kind;
      unique case (code)
         FMT_P4_A, FMT_P4_B, FMT_P4_C:    kind = BPP_4;
         FMT_P8_A, FMT_P8_B:              kind = BPP_8;
         FMT_P16_A, FMT_P16_B, FMT_P16_C: kind = BPP_16;
         FMT_P32:                         kind = BPP_32;
         default:                         kind = BPP_NONE;
      endcase
      return kind;
   endfunction

   // pixel count times bits per pixel, rounded up to whole bytes
   function automatic logic [BYTE_W-1:0] whole_bytes(input logic [PIX_W-1:0] px,
                                                     input bpp_type        kind);
      logic [PIX_W:0]    half_up;
      logic [BYTE_W-1:0] bytes;
      half_up = {1'b0, px} + {{PIX_W{1'b0}}, 1'b1};
      unique case (kind)
         BPP_4:   bytes = {2'b00, half_up[PIX_W:1]};
         BPP_8:   bytes = {2'b00, px};
         BPP_16:  bytes = {1'b0, px, 1'b0};
         BPP_32:  bytes = {px, 2'b00};
         default: bytes = '0;
      endcase
      return bytes;
   endfunction

   function automatic logic [ALN_W-1:0] align16(input logic [BYTE_W-1:0] bytes);
      logic [ALN_W-1:0] sum;
      sum = {1'b0, bytes} + ALN_W'(15);
      return {sum[ALN_W-1:4], 4'b0000};
   endfunction

endpackage

### rtl/core/mcs_if.sv
// ----------------------------------------------------------------------------
// Mip chain size channels
// Valid/ready channels for the texture descriptor and the size result.
// ----------------------------------------------------------------------------
interface mcs_req_if;
   logic        valid;
   logic        ready;
   logic [10:0] width;
   logic [10:0] height;
   logic [3:0]  tex_format;
   logic [3:0]  level_count;
   logic        has_palette;
   logic [3:0]  palette_format;
   logic [14:0] palette_entries;

   modport source (output valid, width, height, tex_format, level_count,
                   has_palette, palette_format, palette_entries, input ready);
   modport sink   (input valid, width, height, tex_format, level_count,
                   has_palette, palette_format, palette_entries, output ready);
endinterface

interface mcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [22:0] level_bytes_0;
   logic [20:0] level_bytes_1;
   logic [18:0] level_bytes_2;
   logic [16:0] level_bytes_3;
   logic [16:0] palette_bytes;
   logic [22:0] total_bytes;
   logic [22:0] raw_level_bytes;
   logic        levels_clamped;

   modport source (output valid, level_bytes_0, level_bytes_1, level_bytes_2,
                   level_bytes_3, palette_bytes, total_bytes, raw_level_bytes,
                   levels_clamped, input ready);
   modport sink   (input valid, level_bytes_0, level_bytes_1, level_bytes_2,
                   level_bytes_3, palette_bytes, total_bytes, raw_level_bytes,
                   levels_clamped, output ready);
endinterface

### rtl/core/mcs_entry.sv
// ----------------------------------------------------------------------------
// Mip chain size entry stage
// Clamps the level count, sizes the palette and seeds the chain token.
// ----------------------------------------------------------------------------
module mcs_entry #(
   parameter int MAX_LEVELS = mcs_pkg::MAX_LEVELS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   mcs_req_if.sink             req_chan,
   output logic                out_valid,
   input  logic                out_ready,
   output mcs_pkg::mcs_tok_type out_tok
);

   localparam logic [mcs_pkg::CNT_W-1:0] MAX_LV = mcs_pkg::CNT_W'(MAX_LEVELS);

   logic                  valid_ff;
   logic                  valid_in;
   mcs_pkg::mcs_tok_type  tok_ff;
   mcs_pkg::mcs_tok_type  tok_in;
   logic                  take;
   logic [mcs_pkg::BYTE_W-1:0] pal_whole;
   logic [mcs_pkg::ALN_W-1:0]  pal_aligned;
   logic [mcs_pkg::PAL_W-1:0]  pal_bytes;

   assign take           = !valid_ff || out_ready;
   assign req_chan.ready = take;
   assign valid_in       = take ? req_chan.valid : valid_ff;

   always_comb begin
      pal_whole   = mcs_pkg::whole_bytes(
                       {{(mcs_pkg::PIX_W - mcs_pkg::PENT_W){1'b0}}, req_chan.palette_entries},
                       mcs_pkg::fmt_to_bpp(req_chan.palette_format));
      pal_aligned = mcs_pkg::align16(pal_whole);
      pal_bytes   = req_chan.has_palette ? pal_aligned[mcs_pkg::PAL_W-1:0] : '0;

      tok_in               = tok_ff;
      tok_in.width         = req_chan.width;
      tok_in.height        = req_chan.height;
      tok_in.bpp           = mcs_pkg::fmt_to_bpp(req_chan.tex_format);
      tok_in.clamped       = req_chan.level_count > MAX_LV;
      tok_in.remaining     = tok_in.clamped ? MAX_LV : req_chan.level_count;
      tok_in.level_bytes   = '0;
      tok_in.palette_bytes = pal_bytes;
      tok_in.total_bytes   = {{(mcs_pkg::SUM_W - mcs_pkg::PAL_W){1'b0}}, pal_bytes};
      tok_in.raw_bytes     = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         tok_ff <= tok_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;

endmodule

### rtl/core/mcs_level_cell.sv
// ----------------------------------------------------------------------------
// Mip chain size level cell
// Sizes one mip level, adds it to the running sums and halves the dimensions
// for the next cell.
// ----------------------------------------------------------------------------
module mcs_level_cell #(
   parameter int LEVEL_IDX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  mcs_pkg::mcs_tok_type in_tok,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mcs_pkg::mcs_tok_type out_tok
);

   localparam bit HAS_FIELD = LEVEL_IDX < mcs_pkg::LEVEL_FIELDS;
   localparam int FIELD_SEL = HAS_FIELD ? LEVEL_IDX : 0;

   logic                       valid_ff;
   logic                       valid_in;
   mcs_pkg::mcs_tok_type       tok_ff;
   mcs_pkg::mcs_tok_type       tok_in;
   logic                       active;
   logic [mcs_pkg::PIX_W-1:0]  pixels;
   logic [mcs_pkg::BYTE_W-1:0] whole;
   logic [mcs_pkg::ALN_W-1:0]  aligned;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      active  = in_tok.remaining != '0;
      pixels  = {{mcs_pkg::DIM_W{1'b0}}, in_tok.width} *
                {{mcs_pkg::DIM_W{1'b0}}, in_tok.height};
      whole   = mcs_pkg::whole_bytes(pixels, in_tok.bpp);
      aligned = mcs_pkg::align16(whole);

      tok_in        = in_tok;
      // hand the next level's dimensions to the neighbor
      tok_in.width  = in_tok.width >> 1;
      tok_in.height = in_tok.height >> 1;
      if (active) begin
         tok_in.remaining   = in_tok.remaining - mcs_pkg::CNT_W'(1);
         tok_in.total_bytes = in_tok.total_bytes + aligned[mcs_pkg::SUM_W-1:0];
         tok_in.raw_bytes   = in_tok.raw_bytes + whole[mcs_pkg::SUM_W-1:0];
         if (HAS_FIELD) begin
            tok_in.level_bytes[FIELD_SEL] = aligned[mcs_pkg::SUM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         tok_ff <= tok_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;

endmodule

### rtl/core/mip_chain_size_calculator_unit.sv
// ----------------------------------------------------------------------------
// Mip chain size calculator
// Sizes the memory of a mipmapped texture and its optional palette.
// ----------------------------------------------------------------------------
// Usage:
//   A texture descriptor arrives on req_chan as one valid/ready transaction;
//   one size result leaves on rsp_chan for every descriptor, in order.
//   The entry stage clamps the level count to MAX_LEVELS and sizes the
//   palette; then a row of MAX_LEVELS level cells follows, each sizing one
//   mip level and handing the halved dimensions and running sums on.
//   An accepted request passes the entry register, then each cell register in
//   turn, before its result is valid. Throughput is one transaction per cycle
//   while rsp_chan.ready is high; every cell is a register stage with its own
//   valid bit, so the chain keeps filling while a result waits.
//   The per-level 11x11 multiplier in each cell sets the stage delay.
//   When the receiver holds rsp_chan.ready low, results back up cell by cell
//   and req_chan.ready drops only once every stage holds a transaction.
//   Synchronous reset clears the valid bit of every stage; token registers are not reset.
// ----------------------------------------------------------------------------
module mip_chain_size_calculator_unit #(
   parameter int MAX_LEVELS = mcs_pkg::MAX_LEVELS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   mcs_req_if.sink   req_chan,
   mcs_rsp_if.source rsp_chan
);

   logic [MAX_LEVELS:0]  stage_valid;
   logic [MAX_LEVELS:0]  stage_ready;
   mcs_pkg::mcs_tok_type stage_tok [MAX_LEVELS+1];
   mcs_pkg::mcs_tok_type last_tok;

   // clamp the count and size the palette
   mcs_entry #(
      .MAX_LEVELS (MAX_LEVELS)
   ) u_entry (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_tok   (stage_tok[0])
   );

   // one cell per mip level
   for (genvar lv = 0; lv < MAX_LEVELS; lv++) begin : g_cell
      mcs_level_cell #(
         .LEVEL_IDX (lv)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[lv]),
         .in_ready  (stage_ready[lv]),
         .in_tok    (stage_tok[lv]),
         .out_valid (stage_valid[lv+1]),
         .out_ready (stage_ready[lv+1]),
         .out_tok   (stage_tok[lv+1])
      );
   end

   // the last cell's register is the output register
   assign last_tok                = stage_tok[MAX_LEVELS];
   assign stage_ready[MAX_LEVELS] = rsp_chan.ready;
   assign rsp_chan.valid          = stage_valid[MAX_LEVELS];

   // drop the upper bits of the level and palette fields
   assign rsp_chan.level_bytes_0   = last_tok.level_bytes[0][22:0];
   assign rsp_chan.level_bytes_1   = last_tok.level_bytes[1][20:0];
   assign rsp_chan.level_bytes_2   = last_tok.level_bytes[2][18:0];
   assign rsp_chan.level_bytes_3   = last_tok.level_bytes[3][16:0];
   assign rsp_chan.palette_bytes   = last_tok.palette_bytes[16:0];
   assign rsp_chan.total_bytes     = last_tok.total_bytes;
   assign rsp_chan.raw_level_bytes = last_tok.raw_bytes;
   assign rsp_chan.levels_clamped  = last_tok.clamped;

   // level fields 0 and 3, the palette and the total leave with their low nibble clear
   a_aligned : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.level_bytes_0[3:0] == 4'd0) &&
                         (rsp_chan.level_bytes_3[3:0] == 4'd0) &&
                         (rsp_chan.palette_bytes[3:0] == 4'd0) &&
                         (rsp_chan.total_bytes[3:0] == 4'd0))
      else $error("unaligned size on the result channel");

   // with no level beyond the fields, the total is the sum of the level fields and the palette
   a_total : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (MAX_LEVELS <= mcs_pkg::LEVEL_FIELDS) |->
         last_tok.total_bytes == 23'(last_tok.level_bytes[0] + last_tok.level_bytes[1] +
                                     last_tok.level_bytes[2] + last_tok.level_bytes[3] +
                                     23'(last_tok.palette_bytes)))
      else $error("total does not match the level and palette sizes");

   // the request side stalls only when the whole chain is full and held
   a_backpressure : assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (&stage_valid) && !rsp_chan.ready)
      else $error("request stalled with room in the chain");

   // a clamped result has used every cell
   a_clamp_count : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.levels_clamped |-> last_tok.remaining == '0)
      else $error("clamped transaction left levels unsized");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mip chain size calculator testbench
// Drives texture descriptors through the request channel, predicts the
// level, palette and total sizes of each one, and checks every result in
// order, with random request idles and result stalls in the later phases.
// ----------------------------------------------------------------------------
module tb;

   localparam int LEVELS      = mcs_pkg::MAX_LEVELS_DEF;
   localparam int PIPE_DEPTH  = LEVELS + 1;   // entry and cell registers on the path
   localparam int STALL_LIMIT = 4000;         // cycles without any transaction
   localparam int PHASE_ITEMS = 445;
   localparam int MAX_REPORTS = 40;

   typedef struct packed {
      logic [mcs_pkg::DIM_W-1:0]  width;
      logic [mcs_pkg::DIM_W-1:0]  height;
      logic [mcs_pkg::FMT_W-1:0]  tex_format;
      logic [mcs_pkg::CNT_W-1:0]  level_count;
      logic                       has_palette;
      logic [mcs_pkg::FMT_W-1:0]  palette_format;
      logic [mcs_pkg::PENT_W-1:0] palette_entries;
   } tex_desc_type;

   typedef struct {
      tex_desc_type desc;
      bit           drain_first;  // hold this one back until all results are in
   } pending_desc_type;

   typedef struct packed {
      logic [22:0] level_bytes_0;
      logic [20:0] level_bytes_1;
      logic [18:0] level_bytes_2;
      logic [16:0] level_bytes_3;
      logic [16:0] palette_bytes;
      logic [22:0] total_bytes;
      logic [22:0] raw_level_bytes;
      logic        levels_clamped;
   } chain_size_type;

   logic clock;
   logic reset;

   mcs_req_if req_if ();
   mcs_rsp_if rsp_if ();

   mip_chain_size_calculator_unit #(
      .MAX_LEVELS (LEVELS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   pending_desc_type pending_q [$];
   chain_size_type   expected_sizes_q [$];
   tex_desc_type     active_desc;
   int               tx_idle_pct;
   int               rx_stall_pct;
   int               error_count;
   int               quiet_cycles;

   always #5 clock = ~clock;

   // --------------------------------------------------------------------------
   // Size prediction
   // --------------------------------------------------------------------------
   // Map a format code to its bits per pixel; unlisted codes size to zero.
   function automatic logic [63:0] format_bits(logic [mcs_pkg::FMT_W-1:0] code);
      case (code)
         mcs_pkg::FMT_P4_A, mcs_pkg::FMT_P4_B, mcs_pkg::FMT_P4_C:    return 64'd4;
         mcs_pkg::FMT_P8_A, mcs_pkg::FMT_P8_B:                       return 64'd8;
         mcs_pkg::FMT_P16_A, mcs_pkg::FMT_P16_B, mcs_pkg::FMT_P16_C: return 64'd16;
         mcs_pkg::FMT_P32:                                           return 64'd32;
         default:                                                    return 64'd0;
      endcase
   endfunction

   // Work out the whole chain exactly in 64 bits, then cut each field to width.
   function automatic chain_size_type size_chain(tex_desc_type d);
      chain_size_type r;
      logic [63:0] lv [mcs_pkg::LEVEL_FIELDS];
      logic [63:0] bpp, used, lw, lh, bytes, aligned, total, raw, pal;
      bpp   = format_bits(d.tex_format);
      used  = 64'(d.level_count);
      total = '0;
      raw   = '0;
      pal   = '0;
      r.levels_clamped = 1'b0;
      if (d.level_count > LEVELS) begin
         used = 64'(LEVELS);
         r.levels_clamped = 1'b1;
      end
      for (int i = 0; i < mcs_pkg::LEVEL_FIELDS; i++) lv[i] = '0;
      for (int i = 0; i < used; i++) begin
         lw      = 64'(d.width) >> i;
         lh      = 64'(d.height) >> i;
         bytes   = (lw * lh * bpp + 64'd7) >> 3;
         aligned = (bytes + 64'd15) & ~64'd15;
         raw     = raw + bytes;
         total   = total + aligned;
         if (i < mcs_pkg::LEVEL_FIELDS) lv[i] = aligned;
      end
      // the palette counts only when present, whatever its other fields hold
      if (d.has_palette) begin
         pal = ((64'(d.palette_entries) * format_bits(d.palette_format) + 64'd7) >> 3);
         pal = (pal + 64'd15) & ~64'd15;
      end
      total = total + pal;
      r.level_bytes_0   = lv[0][22:0];
      r.level_bytes_1   = lv[1][20:0];
      r.level_bytes_2   = lv[2][18:0];
      r.level_bytes_3   = lv[3][16:0];
      r.palette_bytes   = pal[16:0];
      r.total_bytes     = total[22:0];
      r.raw_level_bytes = raw[22:0];
      return r;
   endfunction

   // --------------------------------------------------------------------------
   // Stimulus helpers
   // --------------------------------------------------------------------------
   function automatic tex_desc_type make_desc(int w, int h, int fmt, int lvls, int pal,
                                              int pfmt, int pent);
      tex_desc_type d;
      d.width           = mcs_pkg::DIM_W'(w);
      d.height          = mcs_pkg::DIM_W'(h);
      d.tex_format      = mcs_pkg::FMT_W'(fmt);
      d.level_count     = mcs_pkg::CNT_W'(lvls);
      d.has_palette     = pal[0];
      d.palette_format  = mcs_pkg::FMT_W'(pfmt);
      d.palette_entries = mcs_pkg::PENT_W'(pent);
      return d;
   endfunction

   // Favor the legal range and its edges, with some oversized values.
   function automatic int pick_dim();
      case ($urandom_range(9))
         0:       return 0;
         1:       return 1024;
         2:       return $urandom_range(1025, 2047);
         3:       return $urandom_range(1, 16);
         default: return $urandom_range(1, 1024);
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      if (error_count < MAX_REPORTS) $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // --------------------------------------------------------------------------
   // Driver: present the next pending descriptor whenever the slot is free
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         // record the expected sizes of a transaction accepted at this edge
         if (req_if.valid && req_if.ready) begin
            expected_sizes_q.push_back(size_chain(active_desc));
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct &&
                !(pending_q[0].drain_first && expected_sizes_q.size() != 0)) begin
               active_desc = pending_q[0].desc;
               {req_if.width, req_if.height, req_if.tex_format, req_if.level_count,
                req_if.has_palette, req_if.palette_format,
                req_if.palette_entries} <= pending_q[0].desc;
               req_if.valid <= 1'b1;
               pending_q.pop_front();
            end else begin
               // go idle: nothing queued, a random gap, or a drain hold-off
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Receiver: stall at random, compare each result with the oldest prediction
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      chain_size_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = {rsp_if.level_bytes_0, rsp_if.level_bytes_1, rsp_if.level_bytes_2,
                rsp_if.level_bytes_3, rsp_if.palette_bytes, rsp_if.total_bytes,
                rsp_if.raw_level_bytes, rsp_if.levels_clamped};
         if (expected_sizes_q.size() == 0) begin
            report_mismatch("result transaction with no descriptor outstanding");
         end else begin
            want = expected_sizes_q.pop_front();
            if (got.level_bytes_0 !== want.level_bytes_0)
               report_mismatch($sformatf("level_bytes_0 got %0d want %0d",
                                         got.level_bytes_0, want.level_bytes_0));
            if (got.level_bytes_1 !== want.level_bytes_1)
               report_mismatch($sformatf("level_bytes_1 got %0d want %0d",
                                         got.level_bytes_1, want.level_bytes_1));
            if (got.level_bytes_2 !== want.level_bytes_2)
               report_mismatch($sformatf("level_bytes_2 got %0d want %0d",
                                         got.level_bytes_2, want.level_bytes_2));
            if (got.level_bytes_3 !== want.level_bytes_3)
               report_mismatch($sformatf("level_bytes_3 got %0d want %0d",
                                         got.level_bytes_3, want.level_bytes_3));
            if (got.palette_bytes !== want.palette_bytes)
               report_mismatch($sformatf("palette_bytes got %0d want %0d",
                                         got.palette_bytes, want.palette_bytes));
            if (got.total_bytes !== want.total_bytes)
               report_mismatch($sformatf("total_bytes got %0d want %0d",
                                         got.total_bytes, want.total_bytes));
            if (got.raw_level_bytes !== want.raw_level_bytes)
               report_mismatch($sformatf("raw_level_bytes got %0d want %0d",
                                         got.raw_level_bytes, want.raw_level_bytes));
            if (got.levels_clamped !== want.levels_clamped)
               report_mismatch($sformatf("levels_clamped got %0b want %0b",
                                         got.levels_clamped, want.levels_clamped));
         end
      end
   end

   // --------------------------------------------------------------------------
   // Watchdog: end the run when no transaction moves for too long
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // --------------------------------------------------------------------------
   // Run order: reset, directed descriptors, four random phases, drain, verdict
   // --------------------------------------------------------------------------
   initial begin
      tex_desc_type d;
      int           pick;
      // drive every input to a known value before the first edge
      clock        = 1'b0;
      reset        = 1'b1;
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      error_count  = 0;
      quiet_cycles = 0;
      req_if.valid = 1'b0;
      {req_if.width, req_if.height, req_if.tex_format, req_if.level_count,
       req_if.has_palette, req_if.palette_format, req_if.palette_entries} = '0;
      rsp_if.ready = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty texture, legal maxima, oversized values that wrap,
      // clamping by one and by many, absent levels, a palette flag of zero
      // with live palette fields, and every format code
      pending_q.push_back('{make_desc(0, 0, mcs_pkg::FMT_P4_A, 0, 0, 0, 0), 1'b0});
      pending_q.push_back('{make_desc(1024, 1024, mcs_pkg::FMT_P32, LEVELS, 1,
                                      mcs_pkg::FMT_P32, 16384), 1'b0});
      pending_q.push_back('{make_desc(2047, 2047, mcs_pkg::FMT_P32, 15, 1,
                                      mcs_pkg::FMT_P32, 32767), 1'b0});
      pending_q.push_back('{make_desc(1, 1, mcs_pkg::FMT_P4_A, 1, 1,
                                      mcs_pkg::FMT_P4_B, 1), 1'b0});
      pending_q.push_back('{make_desc(1023, 1, mcs_pkg::FMT_P8_A, LEVELS, 0,
                                      mcs_pkg::FMT_P32, 32767), 1'b0});
      pending_q.push_back('{make_desc(640, 480, mcs_pkg::FMT_P16_A, LEVELS + 1, 1,
                                      mcs_pkg::FMT_P8_B, 255), 1'b0});
      pending_q.push_back('{make_desc(64, 64, mcs_pkg::FMT_P16_B, 2, 1,
                                      mcs_pkg::FMT_P4_C, 0), 1'b0});
      for (int code = 0; code < 16; code++) begin
         pending_q.push_back('{make_desc(5, 3, code, 3, 1, code, 3), 1'b0});
      end

      for (int phase = 0; phase < 4; phase++) begin
         // hold until the previous set has been taken by the block
         while (pending_q.size() != 0 || req_if.valid) @(posedge clock);
         @(negedge clock);
         case (phase)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 73; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
            default: begin
               tx_idle_pct = 30; rx_stall_pct = 30;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            d.width       = mcs_pkg::DIM_W'(pick_dim());
            d.height      = mcs_pkg::DIM_W'(pick_dim());
            d.tex_format  = mcs_pkg::FMT_W'($urandom_range(15));
            // mostly counts within the limit, the rest anywhere in the field
            d.level_count = ($urandom_range(9) < 6) ? mcs_pkg::CNT_W'($urandom_range(LEVELS))
                                                     : mcs_pkg::CNT_W'($urandom_range(15));
            d.has_palette    = 1'($urandom_range(1));
            d.palette_format = mcs_pkg::FMT_W'($urandom_range(15));
            pick = $urandom_range(9);
            case (pick)
               0:       d.palette_entries = '0;
               1:       d.palette_entries = mcs_pkg::PENT_W'(16384);
               2:       d.palette_entries = mcs_pkg::PENT_W'($urandom_range(16385, 32767));
               3:       d.palette_entries = mcs_pkg::PENT_W'($urandom_range(1, 16));
               default: d.palette_entries = mcs_pkg::PENT_W'($urandom_range(16384));
            endcase
            // drain the block mid-phase, and now and then at random
            pending_q.push_back('{d, (n == PHASE_ITEMS / 2) || ($urandom_range(199) == 0)});
         end
      end

      // wait for the last descriptor, then for every result, then a tail
      while (pending_q.size() != 0 || req_if.valid) @(posedge clock);
      while (expected_sizes_q.size() != 0) @(posedge clock);
      repeat (4 * PIPE_DEPTH) @(posedge clock);

      if (error_count == 0 && expected_sizes_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
